@@ src/lpi_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lpi_pkg
// Shared types and constants for the line point interpolator.
// ----------------------------------------------------------------------------
package lpi_pkg;

    localparam int COORD_BITS = 16;
    localparam int FRAC_BITS  = 16;
    localparam int RES_BITS   = 16;
    localparam int ACC_BITS   = COORD_BITS + FRAC_BITS;
    localparam int INC_BITS   = ACC_BITS + 1;
    localparam int DIV_BITS   = (COORD_BITS > RES_BITS) ? COORD_BITS : RES_BITS;
    localparam int CNT_BITS   = $clog2(ACC_BITS);

    typedef logic [COORD_BITS-1:0] coord_t;
    typedef logic [RES_BITS-1:0]   res_t;
    typedef logic [ACC_BITS-1:0]   acc_t;
    typedef logic [INC_BITS-1:0]   inc_t;
    typedef logic [DIV_BITS-1:0]   div_t;
    typedef logic [CNT_BITS-1:0]   cnt_t;

    localparam res_t RES_RESET = res_t'(100);

    // Operation codes of an input word
    localparam logic OP_START = 1'b0;
    localparam logic OP_STEP  = 1'b1;

    // Iteration counts of the shared divider, minus one
    localparam cnt_t CNT_STEPS = cnt_t'(COORD_BITS - 1);
    localparam cnt_t CNT_INCR  = cnt_t'(ACC_BITS - 1);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIV_N,
        ST_DIV_X,
        ST_DIV_Y
    } state_t;

endpackage

@@ src/line_point_interpolator_core.sv @@
`timescale 1ns / 1ps
// A step word's point is in the output register on the next cycle.
// A start word holds the block through the step-count divide (ST_DIV_N) when the line has no
// interpolated steps, else also through the x and y increment divides (ST_DIV_X, ST_DIV_Y); the
// single shared restoring divider computes one quotient bit per cycle.
// Reset (aresetn low, synchronous): position, line state and output valid clear,
// step_resolution returns to 100.
// ----------------------------------------------------------------------------
// line_point_interpolator_core
// Two-axis straight-line point interpolator with a bit-serial shared divider.
// ----------------------------------------------------------------------------
module line_point_interpolator_core (
    input  logic               aclk,
    input  logic               aresetn,
    // configuration
    input  logic               cfg_wr_en,
    input  lpi_pkg::res_t      cfg_wr_data,
    // input words
    input  logic               s_valid,
    output logic               s_ready,
    input  logic               s_operation,
    input  lpi_pkg::coord_t    s_target_x,
    input  lpi_pkg::coord_t    s_target_y,
    // result words
    output logic               m_valid,
    input  logic               m_ready,
    output lpi_pkg::coord_t    m_point_x,
    output lpi_pkg::coord_t    m_point_y,
    output logic               m_x_changed,
    output logic               m_y_changed,
    output logic               m_last_point
);
    import lpi_pkg::*;

    // ------------------------------------------------------------------------
    // Registers
    // ------------------------------------------------------------------------
    state_t state_reg, state_next;
    res_t   res_reg;

    acc_t   accum_x_reg, accum_x_next;
    acc_t   accum_y_reg, accum_y_next;
    inc_t   incr_x_reg, incr_x_next;
    inc_t   incr_y_reg, incr_y_next;
    coord_t steps_left_reg, steps_left_next;
    coord_t line_end_x_reg, line_end_x_next;
    coord_t line_end_y_reg, line_end_y_next;
    coord_t cmd_x_reg, cmd_x_next;
    coord_t cmd_y_reg, cmd_y_next;
    logic   line_active_reg, line_active_next;

    // distances and directions of the line being set up
    coord_t dist_x_reg, dist_x_next;
    coord_t dist_y_reg, dist_y_next;
    logic   neg_x_reg, neg_x_next;
    logic   neg_y_reg, neg_y_next;

    // shared divider
    div_t   rem_reg, rem_next;
    acc_t   quo_reg, quo_next;
    div_t   div_reg, div_next;
    cnt_t   cnt_reg, cnt_next;

    // output register
    logic   out_valid_reg, out_valid_next;
    coord_t out_x_reg, out_x_next;
    coord_t out_y_reg, out_y_next;
    logic   out_xc_reg, out_xc_next;
    logic   out_yc_reg, out_yc_next;
    logic   out_last_reg, out_last_next;

    // ------------------------------------------------------------------------
    // Handshake
    // ------------------------------------------------------------------------
    logic in_accept;
    logic out_free;

    // A start word makes no result, so take it even while a point waits.
    assign out_free  = !out_valid_reg || m_ready;
    assign s_ready   = (state_reg == ST_IDLE) && (out_free || (s_operation == OP_START));
    assign in_accept = s_valid && s_ready;

    assign m_valid      = out_valid_reg;
    assign m_point_x    = out_x_reg;
    assign m_point_y    = out_y_reg;
    assign m_x_changed  = out_xc_reg;
    assign m_y_changed  = out_yc_reg;
    assign m_last_point = out_last_reg;

    // ------------------------------------------------------------------------
    // Shared divider: one restoring step per cycle. The dividend shifts out of
    // the top of quo_reg while quotient bits shift in at the bottom.
    // ------------------------------------------------------------------------
    logic [DIV_BITS:0] trial;
    logic [DIV_BITS:0] trial_diff;
    logic              div_ge;
    div_t              rem_step;
    acc_t              quo_step;
    coord_t            n_quot;
    acc_t              incr_quot;
    logic              div_last;

    assign trial      = {rem_reg, quo_reg[ACC_BITS-1]};
    assign trial_diff = trial - {1'b0, div_reg};
    assign div_ge     = (trial >= {1'b0, div_reg});
    assign rem_step   = div_ge ? trial_diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
    assign quo_step   = {quo_reg[ACC_BITS-2:0], div_ge};
    assign n_quot     = quo_step[COORD_BITS-1:0];
    assign incr_quot  = quo_step;
    assign div_last   = (cnt_reg == '0);

    // ------------------------------------------------------------------------
    // Start-word setup terms
    // ------------------------------------------------------------------------
    logic   tx_ge, ty_ge;
    coord_t ax, ay, amax;
    res_t   res_eff;

    assign tx_ge   = (s_target_x >= cmd_x_reg);
    assign ty_ge   = (s_target_y >= cmd_y_reg);
    assign ax      = tx_ge ? (s_target_x - cmd_x_reg) : (cmd_x_reg - s_target_x);
    assign ay      = ty_ge ? (s_target_y - cmd_y_reg) : (cmd_y_reg - s_target_y);
    assign amax    = (ax > ay) ? ax : ay;
    // a zero resolution acts as one
    assign res_eff = (res_reg == '0) ? res_t'(1) : res_reg;

    // ------------------------------------------------------------------------
    // Step-word terms: advance the accumulators by the increments
    // ------------------------------------------------------------------------
    acc_t   step_acc_x, step_acc_y;
    coord_t step_px, step_py;

    assign step_acc_x = accum_x_reg + incr_x_reg[ACC_BITS-1:0];
    assign step_acc_y = accum_y_reg + incr_y_reg[ACC_BITS-1:0];
    assign step_px    = step_acc_x[ACC_BITS-1:FRAC_BITS];
    assign step_py    = step_acc_y[ACC_BITS-1:FRAC_BITS];

    // ------------------------------------------------------------------------
    // Sequencer: next state
    // ------------------------------------------------------------------------
    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept && (s_operation == OP_START)) begin
                    state_next = ST_DIV_N;
                end
            end
            ST_DIV_N: begin
                if (div_last) begin
                    // no interpolated steps: skip both increment divides
                    state_next = (n_quot == '0) ? ST_IDLE : ST_DIV_X;
                end
            end
            ST_DIV_X: begin
                if (div_last) begin
                    state_next = ST_DIV_Y;
                end
            end
            ST_DIV_Y: begin
                if (div_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // ------------------------------------------------------------------------
    // Sequencer: datapath and output values
    // ------------------------------------------------------------------------
    always_comb begin
        accum_x_next     = accum_x_reg;
        accum_y_next     = accum_y_reg;
        incr_x_next      = incr_x_reg;
        incr_y_next      = incr_y_reg;
        steps_left_next  = steps_left_reg;
        line_end_x_next  = line_end_x_reg;
        line_end_y_next  = line_end_y_reg;
        cmd_x_next       = cmd_x_reg;
        cmd_y_next       = cmd_y_reg;
        line_active_next = line_active_reg;
        dist_x_next      = dist_x_reg;
        dist_y_next      = dist_y_reg;
        neg_x_next       = neg_x_reg;
        neg_y_next       = neg_y_reg;
        rem_next         = rem_reg;
        quo_next         = quo_reg;
        div_next         = div_reg;
        cnt_next         = cnt_reg;
        out_x_next       = out_x_reg;
        out_y_next       = out_y_reg;
        out_xc_next      = out_xc_reg;
        out_yc_next      = out_yc_reg;
        out_last_next    = out_last_reg;
        out_valid_next   = out_valid_reg && !m_ready;

        unique case (state_reg)
            ST_IDLE: begin
                if (in_accept && (s_operation == OP_START)) begin
                    // Abandon any old line; the new one starts at the commanded point.
                    accum_x_next     = {cmd_x_reg, FRAC_BITS'(0)};
                    accum_y_next     = {cmd_y_reg, FRAC_BITS'(0)};
                    line_end_x_next  = s_target_x;
                    line_end_y_next  = s_target_y;
                    line_active_next = 1'b1;
                    dist_x_next      = ax;
                    dist_y_next      = ay;
                    neg_x_next       = !tx_ge;
                    neg_y_next       = !ty_ge;
                    // step count n = longer distance / resolution
                    rem_next         = '0;
                    quo_next         = {amax, FRAC_BITS'(0)};
                    div_next         = div_t'(res_eff);
                    cnt_next         = CNT_STEPS;
                end else if (in_accept) begin
                    if (steps_left_reg != '0) begin
                        accum_x_next    = step_acc_x;
                        accum_y_next    = step_acc_y;
                        steps_left_next = steps_left_reg - coord_t'(1);
                        out_x_next      = step_px;
                        out_y_next      = step_py;
                        out_last_next   = 1'b0;
                        out_valid_next  = 1'b1;
                    end else if (line_active_reg) begin
                        line_active_next = 1'b0;
                        out_x_next       = line_end_x_reg;
                        out_y_next       = line_end_y_reg;
                        out_last_next    = 1'b1;
                        out_valid_next   = 1'b1;
                    end
                    // a step with no line drops silently
                    if ((steps_left_reg != '0) || line_active_reg) begin
                        out_xc_next = (out_x_next != cmd_x_reg);
                        out_yc_next = (out_y_next != cmd_y_reg);
                        cmd_x_next  = out_x_next;
                        cmd_y_next  = out_y_next;
                    end
                end
            end
            ST_DIV_N: begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg - cnt_t'(1);
                if (div_last) begin
                    steps_left_next = n_quot;
                    incr_x_next     = '0;
                    incr_y_next     = '0;
                    // x increment = (dist_x << FRAC_BITS) / n
                    rem_next        = '0;
                    quo_next        = {dist_x_reg, FRAC_BITS'(0)};
                    div_next        = div_t'(n_quot);
                    cnt_next        = CNT_INCR;
                end
            end
            ST_DIV_X: begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg - cnt_t'(1);
                if (div_last) begin
                    incr_x_next = neg_x_reg ? (inc_t'(0) - {1'b0, incr_quot})
                                            : {1'b0, incr_quot};
                    rem_next    = '0;
                    quo_next    = {dist_y_reg, FRAC_BITS'(0)};
                    cnt_next    = CNT_INCR;
                end
            end
            ST_DIV_Y: begin
                rem_next = rem_step;
                quo_next = quo_step;
                cnt_next = cnt_reg - cnt_t'(1);
                if (div_last) begin
                    incr_y_next = neg_y_reg ? (inc_t'(0) - {1'b0, incr_quot})
                                            : {1'b0, incr_quot};
                end
            end
            default: begin
                out_valid_next = 1'b0;
            end
        endcase
    end

    // ------------------------------------------------------------------------
    // Control registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg       <= ST_IDLE;
            res_reg         <= RES_RESET;
            accum_x_reg     <= '0;
            accum_y_reg     <= '0;
            incr_x_reg      <= '0;
            incr_y_reg      <= '0;
            steps_left_reg  <= '0;
            line_end_x_reg  <= '0;
            line_end_y_reg  <= '0;
            cmd_x_reg       <= '0;
            cmd_y_reg       <= '0;
            line_active_reg <= 1'b0;
            cnt_reg         <= '0;
            out_valid_reg   <= 1'b0;
        end else begin
            state_reg       <= state_next;
            if (cfg_wr_en) begin
                res_reg <= cfg_wr_data;
            end
            accum_x_reg     <= accum_x_next;
            accum_y_reg     <= accum_y_next;
            incr_x_reg      <= incr_x_next;
            incr_y_reg      <= incr_y_next;
            steps_left_reg  <= steps_left_next;
            line_end_x_reg  <= line_end_x_next;
            line_end_y_reg  <= line_end_y_next;
            cmd_x_reg       <= cmd_x_next;
            cmd_y_reg       <= cmd_y_next;
            line_active_reg <= line_active_next;
            cnt_reg         <= cnt_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    // ------------------------------------------------------------------------
    // Payload registers
    // ------------------------------------------------------------------------
    always_ff @(posedge aclk) begin
        dist_x_reg   <= dist_x_next;
        dist_y_reg   <= dist_y_next;
        neg_x_reg    <= neg_x_next;
        neg_y_reg    <= neg_y_next;
        rem_reg      <= rem_next;
        quo_reg      <= quo_next;
        div_reg      <= div_next;
        out_x_reg    <= out_x_next;
        out_y_reg    <= out_y_next;
        out_xc_reg   <= out_xc_next;
        out_yc_reg   <= out_yc_next;
        out_last_reg <= out_last_next;
    end

    // ------------------------------------------------------------------------
    // Assertions
    // ------------------------------------------------------------------------
`ifndef SYNTH
    // Hold off input words while the divider runs.
    a_busy_not_ready: assert property (@(posedge aclk) disable iff (!aresetn)
        (state_reg != ST_IDLE) |-> !s_ready)
        else $error("input ready while divider busy");

    // Interpolated steps remain only inside an active line.
    a_steps_in_line: assert property (@(posedge aclk) disable iff (!aresetn)
        (steps_left_reg != '0) |-> line_active_reg)
        else $error("steps left with no active line");

    // The y increment divide ends the setup.
    a_setup_ends: assert property (@(posedge aclk) disable iff (!aresetn)
        ((state_reg == ST_DIV_Y) && div_last) |=> (state_reg == ST_IDLE))
        else $error("setup did not return to idle");

    // A fresh last point has the line target's x and the new commanded y.
    a_last_is_target: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid) && m_last_point |->
            (m_point_x == line_end_x_reg) && (m_point_y == cmd_y_reg))
        else $error("last point differs from line target");
`endif

endmodule
